// File: sv/ttbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttbd_pkg
// Shared types and constants of the tap tempo detector.
// ----------------------------------------------------------------------------
package ttbd_pkg;

  localparam int STAMP_W    = 32;
  localparam int SUM_W      = 34;
  localparam int HIST_DEPTH = 4;
  localparam int SLOT_W     = 2;

  localparam logic [31:0] TPM_RESET = 32'd60000000;

  // last step of each serial unit
  localparam logic [5:0] EVAL_LAST = 6'd34;
  localparam logic [5:0] DIV3_LAST = 6'd33;
  localparam logic [4:0] DIVQ_LAST = 5'd31;
  localparam logic [2:0] READ_LAST = 3'd5;

  typedef logic [STAMP_W-1:0] ttbd_stamp_t;
  typedef ttbd_stamp_t [HIST_DEPTH-1:0] ttbd_hist_t;

  typedef struct packed {
    logic done;
    logic pass;
  } ttbd_eval_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_INTV,
    ST_DIV3,
    ST_DIVQ,
    ST_DONE
  } ttbd_state_t;

endpackage

`default_nettype wire

// File: sv/ttbd_interval_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttbd_interval_eval
// Bit-serial interval former: three intervals, tolerance test and sum.
// ----------------------------------------------------------------------------
module ttbd_interval_eval (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire ttbd_pkg::ttbd_hist_t         stamps,
  output ttbd_pkg::ttbd_eval_t              eval,
  output logic [ttbd_pkg::SUM_W-1:0]        sum
);

  ttbd_pkg::ttbd_hist_t st_r, st_nxt;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [2:0]  bw_r, bw_nxt;
  logic [1:0]  dl_r [3], dl_nxt [3];
  logic        c5a_r, c5a_nxt, c5c_r, c5c_nxt;
  logic [2:0]  lt_r, lt_nxt;
  logic [1:0]  sc_r, sc_nxt;
  logic [ttbd_pkg::SUM_W-1:0] sum_r, sum_nxt;

  logic [2:0] iv;
  logic       in_rng;
  logic       f0, f2;
  logic [2:0] tsum;

  always_comb begin
    in_rng = cnt_r < 6'(ttbd_pkg::STAMP_W);
    for (int j = 0; j < 3; j++) begin
      iv[j] = in_rng & (st_r[j+1][0] ^ st_r[j][0] ^ bw_r[j]);
      bw_nxt[j] = (~st_r[j+1][0] & st_r[j][0]) |
                  (~(st_r[j+1][0] ^ st_r[j][0]) & bw_r[j]);
      dl_nxt[j] = {dl_r[j][0], iv[j]};
      st_nxt[j] = st_r[j] >> 1;
    end
    st_nxt[3] = st_r[3] >> 1;

    // 5x = x + 4x, serially
    f0      = iv[0] ^ dl_r[0][1] ^ c5a_r;
    c5a_nxt = (iv[0] & dl_r[0][1]) | (iv[0] & c5a_r) | (dl_r[0][1] & c5a_r);
    f2      = iv[2] ^ dl_r[2][1] ^ c5c_r;
    c5c_nxt = (iv[2] & dl_r[2][1]) | (iv[2] & c5c_r) | (dl_r[2][1] & c5c_r);

    // LSB-first compare u < v: the highest differing bit decides
    lt_nxt[0] = (dl_r[1][1] != f0) ? f0 : lt_r[0];
    lt_nxt[1] = (dl_r[2][1] != f0) ? f0 : lt_r[1];
    lt_nxt[2] = (dl_r[0][1] != f2) ? f2 : lt_r[2];

    tsum   = 3'(iv[0]) + 3'(iv[1]) + 3'(iv[2]) + 3'(sc_r);
    sc_nxt = tsum[2:1];
    sum_nxt = (cnt_r < 6'(ttbd_pkg::SUM_W)) ? {tsum[0], sum_r[ttbd_pkg::SUM_W-1:1]} : sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == ttbd_pkg::EVAL_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      st_r  <= stamps;
      bw_r  <= '0;
      for (int j = 0; j < 3; j++) dl_r[j] <= '0;
      c5a_r <= 1'b0;
      c5c_r <= 1'b0;
      lt_r  <= '0;
      sc_r  <= '0;
      sum_r <= '0;
    end else if (busy_r) begin
      st_r  <= st_nxt;
      bw_r  <= bw_nxt;
      for (int j = 0; j < 3; j++) dl_r[j] <= dl_nxt[j];
      c5a_r <= c5a_nxt;
      c5c_r <= c5c_nxt;
      lt_r  <= lt_nxt;
      sc_r  <= sc_nxt;
      sum_r <= sum_nxt;
    end
  end

  assign eval.done = done_r;
  assign eval.pass = &lt_r;
  assign sum       = sum_r;

endmodule

`default_nettype wire

// File: sv/ttbd_div3.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttbd_div3
// Serial divide by three, one bit of the sum per cycle, MSB first.
// ----------------------------------------------------------------------------
module ttbd_div3 (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [ttbd_pkg::SUM_W-1:0]    sum,
  output logic                               done,
  output ttbd_pkg::ttbd_stamp_t              quot
);

  logic [ttbd_pkg::SUM_W-1:0] val_r;
  logic [1:0]                 rem_r, rem_nxt;
  ttbd_pkg::ttbd_stamp_t      q_r;
  logic [5:0]                 cnt_r;
  logic                       busy_r, done_r;
  logic [2:0]                 t;
  logic                       qb;

  always_comb begin
    t       = {rem_r, val_r[ttbd_pkg::SUM_W-1]};
    qb      = t >= 3'd3;
    rem_nxt = qb ? 2'(t - 3'd3) : t[1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == ttbd_pkg::DIV3_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient fits 32 bits, the top quotient bits fall off the end
  always_ff @(posedge clk) begin
    if (start) begin
      val_r <= sum;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      val_r <= val_r << 1;
      rem_r <= rem_nxt;
      q_r   <= {q_r[ttbd_pkg::STAMP_W-2:0], qb};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

// File: sv/ttbd_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttbd_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ttbd_divider (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire ttbd_pkg::ttbd_stamp_t dividend,
  input  wire ttbd_pkg::ttbd_stamp_t divisor,
  output logic                       done,
  output ttbd_pkg::ttbd_stamp_t      quot
);

  ttbd_pkg::ttbd_stamp_t dvd_r, dvs_r, rem_r, q_r;
  logic [4:0]            cnt_r;
  logic                  busy_r, done_r;
  logic [ttbd_pkg::STAMP_W:0] t, diff;
  logic                  ge;

  // a zero divisor gives all ones, which is the saturated tempo
  always_comb begin
    t    = {rem_r, dvd_r[ttbd_pkg::STAMP_W-1]};
    diff = t - {1'b0, dvs_r};
    ge   = t >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == ttbd_pkg::DIVQ_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= ge ? diff[ttbd_pkg::STAMP_W-1:0] : t[ttbd_pkg::STAMP_W-1:0];
      q_r   <= {q_r[ttbd_pkg::STAMP_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

// File: sv/tap_tempo_bpm_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tap_tempo_bpm_detector
// Per-channel tap tempo estimator with bit-serial arithmetic.
// ----------------------------------------------------------------------------
// Each input beat carries a channel, a trigger time stamp and the current
// tick count; each one gives exactly one result beat with the channel's held
// tempo, average interval and calculation time, plus accepted/updated flags.
// Both channels use valid/stall; the block stalls its input while an item is
// being worked on. The cfg channel writes ticks_per_minute (cfg_ready is
// always high); write it only while the block is idle.
// Path from acceptance to the result being loaded into the output register:
//   repeated stamp or absent channel: straight to the done state
//   stored stamp, test fails:         ring reads, then the interval pass
//   stored stamp, tempo updated:      ring reads, interval pass, divide by
//                                     three, then the tempo divide
// The ring reads go through the single read port of the memory; the serial
// units then run in turn. One item at a time: the next beat is taken the
// cycle after the result is loaded.
// The result sits in an output register, so a stalled receiver does not hold
// up the next item until its own result is due. Reset clears all history and
// held values and loads ticks_per_minute with 60000000.
// ----------------------------------------------------------------------------
module tap_tempo_bpm_detector #(
  parameter int NUM_CHANNELS = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_channel,
  input  wire logic [31:0] in_trigger_time,
  input  wire logic [31:0] in_now_ticks,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_channel,
  output logic             out_accepted,
  output logic             out_tempo_updated,
  output logic [31:0]      out_bpm,
  output logic [31:0]      out_avg_interval,
  output logic [31:0]      out_calc_time,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_ticks_per_minute
);

  localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ADDR_W    = CH_W + ttbd_pkg::SLOT_W;
  localparam int MEM_DEPTH = NUM_CHANNELS * ttbd_pkg::HIST_DEPTH;

  ttbd_pkg::ttbd_state_t state_r, state_nxt;

  ttbd_pkg::ttbd_stamp_t tpm_r;
  ttbd_pkg::ttbd_stamp_t prev_r       [NUM_CHANNELS];
  logic [ttbd_pkg::SLOT_W-1:0] ptr_r  [NUM_CHANNELS];
  ttbd_pkg::ttbd_stamp_t held_bpm_r   [NUM_CHANNELS];
  ttbd_pkg::ttbd_stamp_t held_int_r   [NUM_CHANNELS];
  ttbd_pkg::ttbd_stamp_t held_calc_r  [NUM_CHANNELS];

  ttbd_pkg::ttbd_stamp_t ring_mem     [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]  ring_vld_r;
  ttbd_pkg::ttbd_stamp_t rd_data_r;
  logic                  rd_vld_r;

  logic [CH_W-1:0]             ch_r;
  logic                        ch_bit_r;
  logic                        present_r, new_r, upd_r;
  logic [ttbd_pkg::SLOT_W-1:0] p_r;
  ttbd_pkg::ttbd_stamp_t       now_r;
  logic [2:0]                  rcnt_r;
  ttbd_pkg::ttbd_hist_t        s_r;

  logic                  out_valid_r, out_channel_r, out_accepted_r, out_upd_r;
  ttbd_pkg::ttbd_stamp_t out_bpm_r, out_avg_r, out_calc_r;

  logic                  in_acc, in_present, in_new, out_free;
  logic [CH_W-1:0]       in_idx;
  ttbd_pkg::ttbd_stamp_t in_prev, rd_stamp;
  logic [ADDR_W-1:0]     wr_addr, rd_addr;
  logic                  front_start, div3_start, divq_start, held_we, out_load;

  ttbd_pkg::ttbd_eval_t       eval;
  logic [ttbd_pkg::SUM_W-1:0] sum;
  logic                       div3_done, divq_done;
  ttbd_pkg::ttbd_stamp_t      avg_q, bpm_q;

  // -------------------------------------------------------------------------
  // input decode
  // -------------------------------------------------------------------------
  always_comb begin
    in_acc     = in_valid & ~in_stall;
    in_present = int'(in_channel) < NUM_CHANNELS;
    in_idx     = CH_W'(in_channel);
    in_prev    = in_present ? prev_r[in_idx] : '0;
    in_new     = in_present && (in_trigger_time != in_prev);
    wr_addr    = {in_idx, (in_present ? ptr_r[in_idx] : '0)};
    // chronological order: oldest slot sits just after the newest
    rd_addr    = {ch_r, ttbd_pkg::SLOT_W'(p_r + rcnt_r[1:0] + 2'd1)};
    rd_stamp   = rd_vld_r ? rd_data_r : '0;
    out_free   = ~out_valid_r | ~out_stall;
  end

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttbd_pkg::ST_IDLE: if (in_acc) begin
        state_nxt = in_new ? ttbd_pkg::ST_READ : ttbd_pkg::ST_DONE;
      end
      ttbd_pkg::ST_READ: if (rcnt_r == ttbd_pkg::READ_LAST) begin
        state_nxt = ttbd_pkg::ST_INTV;
      end
      ttbd_pkg::ST_INTV: if (eval.done) begin
        state_nxt = eval.pass ? ttbd_pkg::ST_DIV3 : ttbd_pkg::ST_DONE;
      end
      ttbd_pkg::ST_DIV3: if (div3_done) begin
        state_nxt = ttbd_pkg::ST_DIVQ;
      end
      ttbd_pkg::ST_DIVQ: if (divq_done) begin
        state_nxt = ttbd_pkg::ST_DONE;
      end
      ttbd_pkg::ST_DONE: if (out_free) begin
        state_nxt = ttbd_pkg::ST_IDLE;
      end
      default: state_nxt = ttbd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    front_start = 1'b0;
    div3_start  = 1'b0;
    divq_start  = 1'b0;
    held_we     = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ttbd_pkg::ST_IDLE: in_stall = 1'b0;
      ttbd_pkg::ST_READ: front_start = rcnt_r == ttbd_pkg::READ_LAST;
      ttbd_pkg::ST_INTV: div3_start = eval.done & eval.pass;
      ttbd_pkg::ST_DIV3: divq_start = div3_done;
      ttbd_pkg::ST_DIVQ: held_we = divq_done;
      ttbd_pkg::ST_DONE: out_load = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttbd_pkg::ST_IDLE;
      rcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ttbd_pkg::ST_READ) begin
        rcnt_r <= rcnt_r + 3'd1;
      end else begin
        rcnt_r <= '0;
      end
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r      <= in_idx;
      ch_bit_r  <= in_channel;
      present_r <= in_present;
      new_r     <= in_new;
      p_r       <= wr_addr[ttbd_pkg::SLOT_W-1:0];
      now_r     <= in_now_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r <= 1'b0;
    end else if (in_acc) begin
      upd_r <= 1'b0;
    end else if (div3_start) begin
      upd_r <= 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // stamp ring: one write and one registered read per cycle
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc && in_new) begin
      ring_mem[wr_addr] <= in_trigger_time;
    end
    rd_data_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (in_acc && in_new) begin
        ring_vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= ring_vld_r[rd_addr];
    end
  end

  // gather four stamps, oldest ends in slot 0
  always_ff @(posedge clk) begin
    if (state_r == ttbd_pkg::ST_READ && rcnt_r != 3'd0 &&
        rcnt_r != ttbd_pkg::READ_LAST) begin
      s_r <= {rd_stamp, s_r[ttbd_pkg::HIST_DEPTH-1:1]};
    end
  end

  // -------------------------------------------------------------------------
  // per-channel state
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpm_r <= ttbd_pkg::TPM_RESET;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        prev_r[c]      <= '0;
        ptr_r[c]       <= '0;
        held_bpm_r[c]  <= '0;
        held_int_r[c]  <= '0;
        held_calc_r[c] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        tpm_r <= cfg_ticks_per_minute;
      end
      if (in_acc && in_new) begin
        prev_r[in_idx] <= in_trigger_time;
        ptr_r[in_idx]  <= ptr_r[in_idx] + 2'd1;
      end
      if (held_we) begin
        held_bpm_r[ch_r]  <= bpm_q;
        held_int_r[ch_r]  <= avg_q;
        held_calc_r[ch_r] <= now_r;
      end
    end
  end

  // -------------------------------------------------------------------------
  // serial units
  // -------------------------------------------------------------------------
  ttbd_interval_eval u_eval (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (front_start),
    .stamps (s_r),
    .eval   (eval),
    .sum    (sum)
  );

  ttbd_div3 u_div3 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div3_start),
    .sum   (sum),
    .done  (div3_done),
    .quot  (avg_q)
  );

  ttbd_divider u_divq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (divq_start),
    .dividend (tpm_r),
    .divisor  (avg_q),
    .done     (divq_done),
    .quot     (bpm_q)
  );

  // -------------------------------------------------------------------------
  // output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel_r  <= ch_bit_r;
      out_accepted_r <= new_r;
      out_upd_r      <= upd_r;
      out_bpm_r      <= present_r ? held_bpm_r[ch_r]  : '0;
      out_avg_r      <= present_r ? held_int_r[ch_r]  : '0;
      out_calc_r     <= present_r ? held_calc_r[ch_r] : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel       = out_channel_r;
  assign out_accepted      = out_accepted_r;
  assign out_tempo_updated = out_upd_r;
  assign out_bpm           = out_bpm_r;
  assign out_avg_interval  = out_avg_r;
  assign out_calc_time     = out_calc_r;
  assign cfg_ready         = 1'b1;

endmodule

`default_nettype wire
